>>> hdl/sme_pkg.sv
// Shared types and constants for the stack machine executor.
// Holds the word formats, opcode and status codes and the arithmetic unit interface.
// No dependencies.
package sme_pkg;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int VALUE_BITS_DEF  = 32;
	localparam int FRAC_BITS       = 16;
	localparam int DEPTH_BITS      = 9;

	localparam logic [DEPTH_BITS-1:0] LIMIT_RESET = 9'd256;

	// Opcodes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_MUL  = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SQRT = 3'd3;
	localparam logic [2:0] OP_OUT  = 3'd4;
	localparam logic [2:0] OP_HALT = 3'd5;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_VALUE   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_SHORT   = 3'd3;
	localparam logic [2:0] ST_BADOP   = 3'd4;
	localparam logic [2:0] ST_NEGSQRT = 3'd5;
	localparam logic [2:0] ST_HALTED  = 3'd6;

	typedef enum logic [1:0] {
		AOP_ADD  = 2'd0,
		AOP_MUL  = 2'd1,
		AOP_SQRT = 2'd2
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] operand;
	} req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic signed [31:0]    out_value;
		logic [DEPTH_BITS-1:0] depth;
	} rsp_t;

endpackage

>>> hdl/sme_stack_ram.sv
// Stack storage: one write port and one read port with registered read data.
// Depends on sme_pkg for default sizes.
module sme_stack_ram #(
	parameter int DEPTH = sme_pkg::STACK_DEPTH_DEF,
	parameter int WIDTH = sme_pkg::VALUE_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/sme_arith.sv
// Iterative arithmetic unit: saturating add, shift-add multiply and digit-by-digit
// square root, all sharing one adder. Depends on sme_pkg.
module sme_arith #(
	parameter int VALUE_BITS = sme_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sme_pkg::arith_req_t    req,
	input  logic [VALUE_BITS-1:0]  a,
	input  logic [VALUE_BITS-1:0]  b,
	output logic [VALUE_BITS-1:0]  result,
	output sme_pkg::arith_sts_t    sts
);

	localparam int VB   = VALUE_BITS;
	localparam int PW   = 2 * VB;
	localparam int SW   = PW + 1;
	localparam int RB   = (VB + sme_pkg::FRAC_BITS + 1) / 2;
	localparam int RW   = 2 * RB;
	localparam int REMW = RB + 3;
	localparam int QW   = PW - sme_pkg::FRAC_BITS;
	localparam int CW   = $clog2(VB + 1);

	localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
	localparam logic [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_ITER = 3'b010,
		A_FIN  = 3'b100
	} astate_t;

	astate_t             state_q;
	sme_pkg::arith_op_t  op_q;
	logic [CW-1:0]       cnt_q;
	logic [PW-1:0]       acc_q;
	logic [VB-1:0]       mcd_q;
	logic [VB-1:0]       mpl_q;
	logic                neg_q;
	logic [RW-1:0]       rad_q;
	logic [RB-1:0]       root_q;
	logic [VB-1:0]       res_q;
	logic                done_q;

	logic [VB-1:0]   mag_a;
	logic [VB-1:0]   mag_b;
	logic [REMW-1:0] rem_sh;
	logic [REMW-1:0] trial;
	logic [QW-1:0]   q_w;
	logic [QW-1:0]   lim;
	logic [VB-1:0]   mag_q;
	logic [VB-1:0]   rootx;
	logic [SW-1:0]   add_x;
	logic [SW-1:0]   add_y;
	logic            add_sub;
	logic [SW-1:0]   add_s;
	logic            ge;

	assign mag_a = a[VB-1] ? (~a + 1'b1) : a;
	assign mag_b = b[VB-1] ? (~b + 1'b1) : b;

	// The square root remainder lives in the low bits of the accumulator.
	assign rem_sh = {acc_q[REMW-3:0], rad_q[RW-1 -: 2]};
	assign trial  = REMW'({root_q, 2'b01});

	assign q_w   = acc_q[PW-1:sme_pkg::FRAC_BITS];
	assign lim   = neg_q ? QW'(VMIN) : QW'(VMAX);
	assign mag_q = (q_w > lim) ? lim[VB-1:0] : q_w[VB-1:0];
	assign rootx = VB'(root_q);

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			A_ITER: begin
				if (op_q == sme_pkg::AOP_SQRT) begin
					add_x   = SW'(rem_sh);
					add_y   = SW'(trial);
					add_sub = 1'b1;
				end else begin
					add_x = {acc_q, 1'b0};
					add_y = mpl_q[VB-1] ? SW'(mcd_q) : '0;
				end
			end
			A_FIN: begin
				if (op_q == sme_pkg::AOP_ADD) begin
					add_x = SW'($signed(mcd_q));
					add_y = SW'($signed(mpl_q));
				end else begin
					// Applies the sign to the clamped product magnitude.
					add_y   = SW'(mag_q);
					add_sub = neg_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign add_s = add_x + (add_sub ? ~add_y : add_y) + SW'(add_sub);
	assign ge    = ~add_s[SW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						state_q <= (req.op == sme_pkg::AOP_ADD) ? A_FIN : A_ITER;
					end
				end
				A_ITER: begin
					if (cnt_q == CW'(1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					acc_q  <= '0;
					root_q <= '0;
					rad_q  <= RW'(a) << sme_pkg::FRAC_BITS;
					neg_q  <= a[VB-1] ^ b[VB-1];
					cnt_q  <= (req.op == sme_pkg::AOP_SQRT) ? CW'(RB) : CW'(VB);
					if (req.op == sme_pkg::AOP_ADD) begin
						mcd_q <= a;
						mpl_q <= b;
					end else begin
						mcd_q <= mag_a;
						mpl_q <= mag_b;
					end
				end
			end
			A_ITER: begin
				cnt_q <= cnt_q - 1'b1;
				if (op_q == sme_pkg::AOP_SQRT) begin
					acc_q  <= PW'(ge ? add_s[REMW-1:0] : rem_sh);
					root_q <= {root_q[RB-2:0], ge};
					rad_q  <= rad_q << 2;
				end else begin
					acc_q <= add_s[PW-1:0];
					mpl_q <= mpl_q << 1;
				end
			end
			A_FIN: begin
				case (op_q)
					sme_pkg::AOP_ADD: begin
						if (add_s[VB] != add_s[VB-1]) begin
							res_q <= add_s[VB] ? VMIN : VMAX;
						end else begin
							res_q <= add_s[VB-1:0];
						end
					end
					sme_pkg::AOP_MUL: res_q <= add_s[VB-1:0];
					default: res_q <= rootx[VB-1] ? VMAX : rootx;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign result = res_q;
	assign sts    = {state_q != A_IDLE, done_q};

endmodule

>>> hdl/stack_machine_executor.sv
// Stack machine executor: one instruction word in, one result word out.
// Push, halt, bad opcode and stack errors go from acceptance straight to the result register; out and
// a negative square root read the top entry first; add, multiply and sqrt read their operands and then
// wait for the shared arithmetic unit, which works one bit per cycle for multiply and sqrt.
// One instruction at a time; the next word is taken the cycle after the result is
// registered, later while an earlier result still waits for rsp_ready.
// Asynchronous active-low reset empties the stack, clears halt and sets the limit to 256.
module stack_machine_executor #(
	parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_BITS  = sme_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  sme_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output sme_pkg::rsp_t                      rsp,
	input  logic                               cfg_we,
	input  logic [sme_pkg::DEPTH_BITS-1:0]     cfg_wdata
);

	localparam int VB   = VALUE_BITS;
	localparam int TW   = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int EW   = VB + 32;
	localparam int CMPW = TW + sme_pkg::DEPTH_BITS;

	localparam logic signed [VB-1:0] VMAX   = {1'b0, {(VB-1){1'b1}}};
	localparam logic signed [VB-1:0] VMIN   = {1'b1, {(VB-1){1'b0}}};
	localparam logic signed [EW-1:0] VMAX_X = EW'(VMAX);
	localparam logic signed [EW-1:0] VMIN_X = EW'(VMIN);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_GOTA = 5'b00010,
		S_GOTB = 5'b00100,
		S_EXEC = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [TW-1:0]                  top_q;
	logic                           halted_q;
	logic [sme_pkg::DEPTH_BITS-1:0] limit_q;
	logic                           rsp_valid_q;
	sme_pkg::rsp_t                  rsp_q;
	logic [2:0]                     op_q;
	logic [VB-1:0]                  a_q;
	logic [2:0]                     status_q;
	logic [31:0]                    val_q;

	logic                  accept;
	logic [TW-1:0]         top_m1;
	logic [TW-1:0]         top_m2;
	logic [CMPW-1:0]       top_w;
	logic                  full;
	logic                  short2;
	logic                  empty;
	logic signed [EW-1:0]  opx;
	logic [VB-1:0]         push_val;
	logic signed [EW-1:0]  rdx;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [VB-1:0]         ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [VB-1:0]         rdata;
	sme_pkg::arith_req_t   arq;
	sme_pkg::arith_sts_t   arith_sts;
	logic [VB-1:0]         arith_a;
	logic [VB-1:0]         arith_res;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;

	assign top_m1 = top_q - 1'b1;
	assign top_m2 = top_q - 2'd2;
	assign top_w  = CMPW'(top_q);
	assign full   = (top_w >= CMPW'(limit_q)) || (top_w >= CMPW'(STACK_DEPTH));
	assign short2 = (top_q < TW'(2));
	assign empty  = (top_q == '0);

	// Pushed immediates saturate when the stored value is narrower than the word.
	assign opx = EW'($signed(req.operand));
	always_comb begin
		if (opx > VMAX_X) begin
			push_val = VMAX;
		end else if (opx < VMIN_X) begin
			push_val = VMIN;
		end else begin
			push_val = opx[VB-1:0];
		end
	end

	assign rdx = EW'($signed(rdata));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && !halted_q) begin
					case (req.req_type)
						sme_pkg::OP_PUSH: begin
							ram_we    = !full;
							ram_waddr = top_q[AW-1:0];
							ram_wdata = push_val;
						end
						sme_pkg::OP_MUL, sme_pkg::OP_ADD: begin
							ram_re    = !short2;
							ram_raddr = top_m1[AW-1:0];
						end
						sme_pkg::OP_SQRT, sme_pkg::OP_OUT: begin
							ram_re    = !empty;
							ram_raddr = top_m1[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			S_GOTA: begin
				if (op_q == sme_pkg::OP_MUL || op_q == sme_pkg::OP_ADD) begin
					ram_re    = 1'b1;
					ram_raddr = top_m2[AW-1:0];
				end
			end
			S_EXEC: begin
				if (arith_sts.done) begin
					ram_we    = 1'b1;
					ram_waddr = (op_q == sme_pkg::OP_SQRT) ? top_m1[AW-1:0] : top_m2[AW-1:0];
					ram_wdata = arith_res;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		arq.start = (state_q == S_GOTB) ||
			(state_q == S_GOTA && op_q == sme_pkg::OP_SQRT && !rdata[VB-1]);
		if (op_q == sme_pkg::OP_MUL) begin
			arq.op = sme_pkg::AOP_MUL;
		end else if (op_q == sme_pkg::OP_ADD) begin
			arq.op = sme_pkg::AOP_ADD;
		end else begin
			arq.op = sme_pkg::AOP_SQRT;
		end
	end

	assign arith_a = (state_q == S_GOTB) ? a_q : rdata;

	sme_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (VB)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	sme_arith #(
		.VALUE_BITS (VB)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arq),
		.a      (arith_a),
		.b      (rdata),
		.result (arith_res),
		.sts    (arith_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= '0;
			halted_q    <= 1'b0;
			limit_q     <= sme_pkg::LIMIT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (state_q == S_FIN && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (halted_q) begin
							state_q <= S_FIN;
						end else begin
							case (req.req_type)
								sme_pkg::OP_PUSH: begin
									if (!full) begin
										top_q <= top_q + 1'b1;
									end
									state_q <= S_FIN;
								end
								sme_pkg::OP_MUL, sme_pkg::OP_ADD: begin
									state_q <= short2 ? S_FIN : S_GOTA;
								end
								sme_pkg::OP_SQRT, sme_pkg::OP_OUT: begin
									state_q <= empty ? S_FIN : S_GOTA;
								end
								sme_pkg::OP_HALT: begin
									halted_q <= 1'b1;
									state_q  <= S_FIN;
								end
								default: state_q <= S_FIN;
							endcase
						end
					end
				end
				S_GOTA: begin
					if (op_q == sme_pkg::OP_OUT) begin
						top_q   <= top_m1;
						state_q <= S_FIN;
					end else if (op_q == sme_pkg::OP_SQRT) begin
						state_q <= rdata[VB-1] ? S_FIN : S_EXEC;
					end else begin
						state_q <= S_GOTB;
					end
				end
				S_GOTB: state_q <= S_EXEC;
				S_EXEC: begin
					if (arith_sts.done) begin
						// Add and multiply leave one entry where there were two.
						if (op_q != sme_pkg::OP_SQRT) begin
							top_q <= top_m1;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= req.req_type;
					val_q <= '0;
					if (halted_q) begin
						status_q <= sme_pkg::ST_HALTED;
					end else begin
						case (req.req_type)
							sme_pkg::OP_PUSH: status_q <= full ? sme_pkg::ST_FULL : sme_pkg::ST_OK;
							sme_pkg::OP_MUL, sme_pkg::OP_ADD: begin
								status_q <= short2 ? sme_pkg::ST_SHORT : sme_pkg::ST_OK;
							end
							sme_pkg::OP_SQRT, sme_pkg::OP_OUT: begin
								status_q <= empty ? sme_pkg::ST_SHORT : sme_pkg::ST_OK;
							end
							sme_pkg::OP_HALT: status_q <= sme_pkg::ST_HALTED;
							default: status_q <= sme_pkg::ST_BADOP;
						endcase
					end
				end
			end
			S_GOTA: begin
				a_q <= rdata;
				if (op_q == sme_pkg::OP_OUT) begin
					status_q <= sme_pkg::ST_VALUE;
					val_q    <= rdx[31:0];
				end else if (op_q == sme_pkg::OP_SQRT && rdata[VB-1]) begin
					status_q <= sme_pkg::ST_NEGSQRT;
				end
			end
			S_FIN: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_q.status    <= status_q;
					rsp_q.out_value <= val_q;
					rsp_q.depth     <= top_w[sme_pkg::DEPTH_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_w <= CMPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> $stable(top_q))
		else $error("stack changed while halted");

	a_done_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		arith_sts.done |-> state_q == S_EXEC)
		else $error("arithmetic result outside execute state");

	a_idle_unit: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !arith_sts.busy)
		else $error("new word taken while arithmetic unit busy");

endmodule

>>> tb/tb_stack_machine_executor.sv
// Self-checking testbench for stack_machine_executor, driving instruction words through the
// valid/ready channels and checking every result word against an in-bench stack predictor.
// Depends on sme_pkg and the stack_machine_executor RTL only.
`timescale 1ns / 100ps

module tb_stack_machine_executor;

	localparam logic [2:0] OP_BAD_LO = 3'd6;
	localparam logic [2:0] OP_BAD_HI = 3'd7;
	localparam longint VALUE_MAX = 64'sh7FFF_FFFF;
	localparam longint VALUE_MIN = -64'sh8000_0000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	sme_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	sme_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [sme_pkg::DEPTH_BITS-1:0] cfg_wdata = '0;

	sme_pkg::req_t program_words[$];
	sme_pkg::rsp_t awaited_results[$];
	sme_pkg::rsp_t head_result;
	int faults = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	// Shadow copy of the machine state, advanced once per accepted word.
	logic signed [31:0] shadow_stack[sme_pkg::STACK_DEPTH_DEF];
	int shadow_top = 0;
	bit shadow_halted = 1'b0;
	logic [sme_pkg::DEPTH_BITS-1:0] shadow_limit = sme_pkg::LIMIT_RESET;

	stack_machine_executor dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [31:0] fixed_sum(logic signed [31:0] a,
			logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > VALUE_MAX) return 32'sh7FFF_FFFF;
		if (s < VALUE_MIN) return 32'sh8000_0000;
		return 32'(s);
	endfunction

	// Magnitudes are multiplied and then shifted, so the fraction is cut toward zero.
	function automatic logic signed [31:0] fixed_product(logic signed [31:0] a,
			logic signed [31:0] b);
		logic [63:0] ma, mb, q, lim;
		logic neg;
		neg = a[31] ^ b[31];
		ma = a[31] ? 64'(-longint'(a)) : 64'(longint'(a));
		mb = b[31] ? 64'(-longint'(b)) : 64'(longint'(b));
		q = (ma * mb) >> sme_pkg::FRAC_BITS;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q > lim) q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic logic [31:0] fixed_root(logic [31:0] x);
		logic [63:0] radicand, trial, root;
		radicand = {16'b0, x, 16'b0};
		root = '0;
		for (int b = 23; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= radicand) root = trial;
		end
		return root[31:0];
	endfunction

	function automatic sme_pkg::rsp_t run_instruction(sme_pkg::req_t w);
		sme_pkg::rsp_t r;
		int cap;
		logic signed [31:0] a, b;
		r.status = sme_pkg::ST_OK;
		r.out_value = '0;
		cap = (int'(shadow_limit) < sme_pkg::STACK_DEPTH_DEF) ?
			int'(shadow_limit) : sme_pkg::STACK_DEPTH_DEF;
		if (shadow_halted) begin
			r.status = sme_pkg::ST_HALTED;
		end else begin
			case (w.req_type)
				sme_pkg::OP_PUSH: begin
					if (shadow_top >= cap) begin
						r.status = sme_pkg::ST_FULL;
					end else begin
						shadow_stack[shadow_top] = w.operand;
						shadow_top++;
					end
				end
				sme_pkg::OP_MUL, sme_pkg::OP_ADD: begin
					if (shadow_top < 2) begin
						r.status = sme_pkg::ST_SHORT;
					end else begin
						a = shadow_stack[shadow_top-1];
						b = shadow_stack[shadow_top-2];
						shadow_top--;
						shadow_stack[shadow_top-1] = (w.req_type == sme_pkg::OP_MUL) ?
							fixed_product(a, b) : fixed_sum(a, b);
					end
				end
				sme_pkg::OP_SQRT: begin
					if (shadow_top == 0) begin
						r.status = sme_pkg::ST_SHORT;
					end else if (shadow_stack[shadow_top-1] < 0) begin
						r.status = sme_pkg::ST_NEGSQRT;
					end else begin
						shadow_stack[shadow_top-1] = fixed_root(shadow_stack[shadow_top-1]);
					end
				end
				sme_pkg::OP_OUT: begin
					if (shadow_top == 0) begin
						r.status = sme_pkg::ST_SHORT;
					end else begin
						shadow_top--;
						r.status = sme_pkg::ST_VALUE;
						r.out_value = shadow_stack[shadow_top];
					end
				end
				sme_pkg::OP_HALT: begin
					shadow_halted = 1'b1;
					r.status = sme_pkg::ST_HALTED;
				end
				default: begin
					r.status = sme_pkg::ST_BADOP;
				end
			endcase
		end
		r.depth = shadow_top[sme_pkg::DEPTH_BITS-1:0];
		return r;
	endfunction

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 38);
	endfunction

	function automatic bit machine_busy();
		return program_words.size() != 0 || req_valid || awaited_results.size() != 0;
	endfunction

	// Halt is never drawn here; it is kept for the closing part of the run.
	function automatic sme_pkg::req_t random_word(int push_pct);
		sme_pkg::req_t w;
		case ($urandom_range(7))
			0: w.operand = 32'sh7FFF_FFFF;
			1: w.operand = 32'sh8000_0000;
			2: w.operand = '0;
			3: w.operand = 32'($urandom_range(32'h3_FFFF)) - 32'sh2_0000;
			4, 5: w.operand = 32'($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
			default: w.operand = $urandom;
		endcase
		if ($urandom_range(99) < push_pct) begin
			w.req_type = sme_pkg::OP_PUSH;
		end else if ($urandom_range(11) == 0) begin
			w.req_type = $urandom_range(1) ? OP_BAD_HI : OP_BAD_LO;
		end else begin
			case ($urandom_range(3))
				0: w.req_type = sme_pkg::OP_MUL;
				1: w.req_type = sme_pkg::OP_ADD;
				2: w.req_type = sme_pkg::OP_SQRT;
				default: w.req_type = sme_pkg::OP_OUT;
			endcase
		end
		return w;
	endfunction

	task automatic queue_word(input logic [2:0] op, input logic [31:0] value);
		sme_pkg::req_t w;
		w.req_type = op;
		w.operand = value;
		program_words.push_back(w);
	endtask

	// The limit only changes once every result of the previous words has come back.
	task automatic run_phase(input logic [sme_pkg::DEPTH_BITS-1:0] limit_value,
			input int count, input int push_pct, input bit calm);
		while (machine_busy()) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= limit_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		steady = calm;
		repeat (count) program_words.push_back(random_word(push_pct));
	endtask

	// Driver: the predictor runs on each accepted word, in acceptance order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) shadow_limit = cfg_wdata;
			if (req_valid && req_ready) awaited_results.push_back(run_instruction(req));
			if (!req_valid || req_ready) begin
				if (program_words.size() != 0 && !take_break()) begin
					req_valid <= 1'b1;
					req <= program_words.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result word, status %0d value %h depth %0d",
						$time, rsp.status, rsp.out_value, rsp.depth);
					faults++;
				end else begin
					head_result = awaited_results.pop_front();
					if (rsp.status !== head_result.status) begin
						$display("%0t: status expected %0d, got %0d",
							$time, head_result.status, rsp.status);
						faults++;
					end
					if (rsp.out_value !== head_result.out_value) begin
						$display("%0t: out_value expected %h, got %h",
							$time, head_result.out_value, rsp.out_value);
						faults++;
					end
					if (rsp.depth !== head_result.depth) begin
						$display("%0t: depth expected %0d, got %0d",
							$time, head_result.depth, rsp.depth);
						faults++;
					end
				end
			end
			rsp_ready <= !take_break();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty-stack errors, saturating add and multiply, negative root, truncation, bad opcodes.
		queue_word(sme_pkg::OP_OUT, 32'h0);
		queue_word(sme_pkg::OP_SQRT, 32'h0);
		queue_word(sme_pkg::OP_ADD, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
		queue_word(sme_pkg::OP_MUL, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
		queue_word(sme_pkg::OP_ADD, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h8000_0000);
		queue_word(sme_pkg::OP_PUSH, 32'h8000_0000);
		queue_word(sme_pkg::OP_ADD, 32'h0);
		queue_word(sme_pkg::OP_MUL, 32'h0);
		queue_word(sme_pkg::OP_SQRT, 32'h0);
		queue_word(sme_pkg::OP_OUT, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h0001_0000);
		queue_word(sme_pkg::OP_PUSH, 32'hFFFF_0000);
		queue_word(sme_pkg::OP_MUL, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h0000_0003);
		queue_word(sme_pkg::OP_PUSH, 32'hFFFF_8000);
		queue_word(sme_pkg::OP_MUL, 32'h0);
		queue_word(sme_pkg::OP_ADD, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h0002_0000);
		queue_word(sme_pkg::OP_SQRT, 32'h0);
		queue_word(sme_pkg::OP_PUSH, 32'h0);
		queue_word(sme_pkg::OP_SQRT, 32'h0);
		queue_word(OP_BAD_LO, 32'h1234_5678);
		queue_word(OP_BAD_HI, 32'hFFFF_FFFF);

		run_phase(9'd1, 90, 50, 1'b0);
		run_phase(9'd0, 60, 50, 1'b0);
		run_phase(9'd256, 400, 80, 1'b0);
		run_phase(9'd511, 150, 40, 1'b0);
		run_phase(9'd3, 150, 50, 1'b1);
		run_phase(9'd256, 250, 55, 1'b0);

		// Once halted the machine answers every further word with the halted status.
		while (machine_busy()) @(posedge clk);
		queue_word(sme_pkg::OP_PUSH, 32'h0003_0000);
		queue_word(sme_pkg::OP_HALT, $urandom);
		repeat (40) queue_word(3'($urandom_range(7)), $urandom);

		while (machine_busy()) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (faults == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/sme_pkg.sv
hdl/sme_stack_ram.sv
hdl/sme_arith.sv
hdl/stack_machine_executor.sv
tb/tb_stack_machine_executor.sv
